>>> design/fqsr_pkg.sv
`timescale 1ns / 1ps

package fqsr_pkg;

  localparam int DEPTH_DEFAULT      = 64;
  localparam int DATA_WIDTH_DEFAULT = 32;

  typedef enum logic [2:0] {
    OP_PUSH     = 3'd0,
    OP_POP      = 3'd1,
    OP_CONTAIN  = 3'd2,
    OP_REVERSE  = 3'd3,
    OP_EXCHANGE = 3'd4,
    OP_CLEAR    = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_SEARCH,
    S_EXCH,
    S_DONE
  } state_t;

  // Controller to output stage: result ready plus its flags.
  typedef struct packed {
    logic    done;
    status_t status;
    logic    found;
    logic    empty;
  } ctrl_stat_t;

endpackage

>>> design/fifo_queue_with_search_reverse_unit.sv
`timescale 1ns / 1ps
// Sequence: a pop of two or more entries passes S_POP and exchange ends on a nonempty queue
//   passes S_EXCH before S_DONE; contain on a nonempty queue walks S_SEARCH first; the rest go
//   straight to S_DONE. Throughput: push runs one per cycle unless out_stall holds; contain is
//   set by the single read port walking the ring store one entry a cycle.
// Reset: rst clears head, count, orientation and the handshake state; the ring store keeps
//   whatever it held and needs no clearing pass, since only entries written by a push or exchange are read.
module fifo_queue_with_search_reverse_unit #(
  parameter int DEPTH      = fqsr_pkg::DEPTH_DEFAULT,
  parameter int DATA_WIDTH = fqsr_pkg::DATA_WIDTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         op,
  input  logic signed [31:0] value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic               found,
  output logic signed [31:0] front_value,
  output logic signed [31:0] back_value,
  output logic [6:0]         count,
  output logic               is_empty
);

  localparam int AW = $clog2(DEPTH);

  fqsr_pkg::ctrl_stat_t  stat;
  logic                  out_free;
  logic [31:0]           res_front;
  logic [31:0]           res_back;
  logic [6:0]            res_count;
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [DATA_WIDTH-1:0] ram_wdata;
  logic                  ram_re;
  logic [AW-1:0]         ram_raddr;
  logic [DATA_WIDTH-1:0] ram_rdata;

  // The output register is free when empty or being drained this cycle.
  assign out_free = !out_valid || !out_stall;

  // Sequencer: owns head, count, orientation and cached front/back values, and
  // runs the read-modify-write steps against the ring store.
  fqsr_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .op        (op),
    .value     (value),
    .out_free  (out_free),
    .stat      (stat),
    .res_front (res_front),
    .res_back  (res_back),
    .res_count (res_count),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  // Ring store: one write port, one registered read port.
  fqsr_ram #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Output register: load a finished transaction, hold it while stalled,
  // drop valid once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stat.done) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.done) begin
      status      <= stat.status;
      found       <= stat.found;
      front_value <= res_front;
      back_value  <= res_back;
      count       <= res_count;
      is_empty    <= stat.empty;
    end
  end

  // A result is only loaded into a free output register.
  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    stat.done |-> out_free)
    else $error("result loaded over a stalled transaction");

  // An empty queue reports zero front and back values.
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && is_empty) |-> (front_value == 32'sd0 && back_value == 32'sd0))
    else $error("empty queue reports nonzero ends");

  // A full error can only come from a queue that holds entries.
  a_full_not_empty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == fqsr_pkg::ST_FULL) |-> !is_empty)
    else $error("full status on an empty queue");

  // A search hit is only reported with ok status.
  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && found) |-> (status == fqsr_pkg::ST_OK))
    else $error("found flag with error status");

endmodule

>>> design/fqsr_ram.sv
`timescale 1ns / 1ps

module fqsr_ram #(
  parameter int DEPTH      = fqsr_pkg::DEPTH_DEFAULT,
  parameter int DATA_WIDTH = fqsr_pkg::DATA_WIDTH_DEFAULT
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_WIDTH-1:0]    wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_WIDTH-1:0]    rdata
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/fqsr_ctrl.sv
`timescale 1ns / 1ps

module fqsr_ctrl #(
  parameter int DEPTH      = fqsr_pkg::DEPTH_DEFAULT,
  parameter int DATA_WIDTH = fqsr_pkg::DATA_WIDTH_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [2:0]               op,
  input  logic signed [31:0]       value,
  input  logic                     out_free,
  output fqsr_pkg::ctrl_stat_t     stat,
  output logic [31:0]              res_front,
  output logic [31:0]              res_back,
  output logic [6:0]               res_count,
  output logic                     ram_we,
  output logic [$clog2(DEPTH)-1:0] ram_waddr,
  output logic [DATA_WIDTH-1:0]    ram_wdata,
  output logic                     ram_re,
  output logic [$clog2(DEPTH)-1:0] ram_raddr,
  input  logic [DATA_WIDTH-1:0]    ram_rdata
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = AW + 2;

  // Physical slot of logical position p from head h, in either orientation.
  function automatic logic [AW-1:0] slot(logic [AW-1:0] h, logic [CW-1:0] p, logic r);
    logic [IW-1:0] s;
    if (r) begin
      s = IW'(h) + IW'(DEPTH) - IW'(p);
    end else begin
      s = IW'(h) + IW'(p);
    end
    if (s >= IW'(DEPTH)) begin
      s = s - IW'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  fqsr_pkg::state_t  state, state_next;
  fqsr_pkg::status_t status;
  fqsr_pkg::op_t     op_code;

  logic [AW-1:0]         head;
  logic [CW-1:0]         cnt;
  logic                  rev;
  logic [DATA_WIDTH-1:0] front;
  logic [DATA_WIDTH-1:0] back;
  logic [DATA_WIDTH-1:0] key;
  logic [AW-1:0]         ptr;
  logic [CW-1:0]         left;
  logic                  rd_pend;
  logic                  found;

  logic                  ready;
  logic                  accept;
  logic                  is_zero;
  logic                  is_full;
  logic [AW-1:0]         tail_slot;
  logic [AW-1:0]         push_slot;
  logic [AW-1:0]         next_slot;
  logic [DATA_WIDTH-1:0] data_in;
  logic signed [63:0]    val_ext;
  logic signed [63:0]    front_ext;
  logic signed [63:0]    back_ext;

  assign op_code   = fqsr_pkg::op_t'(op);
  assign val_ext   = 64'(value);
  assign data_in   = val_ext[DATA_WIDTH-1:0];
  assign front_ext = 64'(signed'(front));
  assign back_ext  = 64'(signed'(back));

  assign is_zero   = (cnt == '0);
  assign is_full   = (cnt == CW'(DEPTH));
  assign tail_slot = slot(head, CW'(cnt - CW'(1)), rev);
  assign push_slot = slot(head, cnt, rev);
  assign next_slot = slot(head, CW'(1), rev);

  assign ready    = (state == fqsr_pkg::S_IDLE) || ((state == fqsr_pkg::S_DONE) && out_free);
  assign in_stall = !ready;
  assign accept   = in_valid && ready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      fqsr_pkg::S_IDLE, fqsr_pkg::S_DONE: begin
        if (accept) begin
          unique case (op_code)
            fqsr_pkg::OP_POP:
              state_next = (is_zero || (cnt == CW'(1))) ? fqsr_pkg::S_DONE : fqsr_pkg::S_POP;
            fqsr_pkg::OP_CONTAIN:
              state_next = is_zero ? fqsr_pkg::S_DONE : fqsr_pkg::S_SEARCH;
            fqsr_pkg::OP_EXCHANGE:
              state_next = is_zero ? fqsr_pkg::S_DONE : fqsr_pkg::S_EXCH;
            default:
              state_next = fqsr_pkg::S_DONE;
          endcase
        end else if (state == fqsr_pkg::S_DONE && out_free) begin
          state_next = fqsr_pkg::S_IDLE;
        end
      end
      fqsr_pkg::S_POP:  state_next = fqsr_pkg::S_DONE;
      fqsr_pkg::S_EXCH: state_next = fqsr_pkg::S_DONE;
      fqsr_pkg::S_SEARCH: begin
        if (left == '0 && !rd_pend) begin
          state_next = fqsr_pkg::S_DONE;
        end
      end
      default: state_next = fqsr_pkg::S_IDLE;
    endcase
  end

  // memory port drive and result
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = push_slot;
    ram_wdata = data_in;
    ram_re    = 1'b0;
    ram_raddr = ptr;
    if (accept) begin
      unique case (op_code)
        fqsr_pkg::OP_PUSH: ram_we = !is_full;
        fqsr_pkg::OP_POP: begin
          ram_re    = !is_zero;
          ram_raddr = next_slot;
        end
        fqsr_pkg::OP_EXCHANGE: begin
          ram_we    = !is_zero;
          ram_waddr = head;
          ram_wdata = back;
        end
        default: ;
      endcase
    end else if (state == fqsr_pkg::S_SEARCH) begin
      ram_re = (left != '0);
    end else if (state == fqsr_pkg::S_EXCH) begin
      // back already holds the old front
      ram_we    = 1'b1;
      ram_waddr = tail_slot;
      ram_wdata = back;
    end

    stat.done   = (state == fqsr_pkg::S_DONE) && out_free;
    stat.status = status;
    stat.found  = found;
    stat.empty  = is_zero;
    res_front   = is_zero ? 32'd0 : front_ext[31:0];
    res_back    = is_zero ? 32'd0 : back_ext[31:0];
    res_count   = 7'(cnt);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= fqsr_pkg::S_IDLE;
      head    <= '0;
      cnt     <= '0;
      rev     <= 1'b0;
      status  <= fqsr_pkg::ST_OK;
      found   <= 1'b0;
      rd_pend <= 1'b0;
      ptr     <= '0;
      left    <= '0;
    end else begin
      state   <= state_next;
      rd_pend <= (state == fqsr_pkg::S_SEARCH) && (left != '0);
      if (accept) begin
        found  <= 1'b0;
        key    <= data_in;
        unique case (op_code)
          fqsr_pkg::OP_PUSH: begin
            if (is_full) begin
              status <= fqsr_pkg::ST_FULL;
            end else begin
              status <= fqsr_pkg::ST_OK;
              cnt    <= CW'(cnt + CW'(1));
              back   <= data_in;
              if (is_zero) begin
                front <= data_in;
              end
            end
          end
          fqsr_pkg::OP_POP: begin
            if (is_zero) begin
              status <= fqsr_pkg::ST_EMPTY;
            end else begin
              status <= fqsr_pkg::ST_OK;
              head   <= next_slot;
              cnt    <= CW'(cnt - CW'(1));
            end
          end
          fqsr_pkg::OP_CONTAIN: begin
            if (is_zero) begin
              status <= fqsr_pkg::ST_EMPTY;
            end else begin
              status <= fqsr_pkg::ST_OK;
              ptr    <= head;
              left   <= cnt;
            end
          end
          fqsr_pkg::OP_REVERSE: begin
            if (is_zero) begin
              status <= fqsr_pkg::ST_EMPTY;
            end else begin
              status <= fqsr_pkg::ST_OK;
              head   <= tail_slot;
              rev    <= !rev;
              front  <= back;
              back   <= front;
            end
          end
          fqsr_pkg::OP_EXCHANGE: begin
            if (is_zero) begin
              status <= fqsr_pkg::ST_EMPTY;
            end else begin
              status <= fqsr_pkg::ST_OK;
              front  <= back;
              back   <= front;
            end
          end
          fqsr_pkg::OP_CLEAR: begin
            if (is_zero) begin
              status <= fqsr_pkg::ST_EMPTY;
            end else begin
              status <= fqsr_pkg::ST_OK;
              cnt    <= '0;
              head   <= '0;
              rev    <= 1'b0;
            end
          end
          default: status <= fqsr_pkg::ST_OK;
        endcase
      end
      if (state == fqsr_pkg::S_POP) begin
        front <= ram_rdata;
      end
      if (state == fqsr_pkg::S_SEARCH) begin
        if (left != '0) begin
          ptr  <= slot(ptr, CW'(1), rev);
          left <= CW'(left - CW'(1));
        end
        if (rd_pend && ram_rdata == key) begin
          found <= 1'b1;
        end
      end
    end
  end

endmodule
